>>> rtl/ddm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ddm_pkg
// Shared types and constants of the differential drive mixer.
// ---------------------------------------------------------------------------
package ddm_pkg;

   localparam int QFRAC  = 14;
   localparam int CMDW   = 16;
   localparam int NSTEP  = QFRAC;
   localparam int ADDRW  = 4;
   localparam int DATAW  = 32;

   typedef logic [QFRAC:0]          mag_type;
   typedef logic [QFRAC+1:0]        wmag_type;
   typedef logic signed [QFRAC+2:0] wsum_type;
   typedef logic [QFRAC-1:0]        quo_type;
   typedef logic signed [CMDW-1:0]  cmd_type;

   localparam mag_type QONE          = mag_type'(1 << QFRAC);
   localparam mag_type MAX_SPEED_RST = mag_type'(13107);
   localparam mag_type BACKWARD_RST  = mag_type'(8192);

   typedef enum logic [1:0] {
      REG_MAX_SPEED  = 2'd0,
      REG_BACKWARD   = 2'd1,
      REG_ADV_INVERT = 2'd2,
      REG_TRN_INVERT = 2'd3
   } reg_addr_type;

   typedef struct packed {
      mag_type max_speed;
      mag_type backward_factor;
      logic    advance_invert;
      logic    turn_invert;
   } cfg_type;

   typedef struct packed {
      logic     norm;
      logic     left_big;
      logic     equal;
      logic     left_neg;
      logic     right_neg;
      wmag_type left_mag;
      wmag_type right_mag;
   } side_type;

   typedef struct packed {
      side_type side;
      wmag_type num;
      wmag_type den;
   } div_in_type;

endpackage

>>> rtl/ddm_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ddm_req_if / ddm_rsp_if
// Valid/ready channels for command items and wheel speed items.
// ---------------------------------------------------------------------------
interface ddm_req_if;
   logic                  valid;
   logic                  ready;
   logic signed [15:0]    advance_cmd;
   logic signed [15:0]    turn_cmd;

   modport source (output valid, output advance_cmd, output turn_cmd, input ready);
   modport sink   (input valid, input advance_cmd, input turn_cmd, output ready);
endinterface

interface ddm_rsp_if;
   logic                  valid;
   logic                  ready;
   logic signed [15:0]    left_speed;
   logic signed [15:0]    right_speed;

   modport source (output valid, output left_speed, output right_speed, input ready);
   modport sink   (input valid, input left_speed, input right_speed, output ready);
endinterface

>>> rtl/ddm_csr.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ddm_csr
// APB-style register file holding the speed limits and invert controls.
// ---------------------------------------------------------------------------
module ddm_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ddm_pkg::ADDRW-1:0]   paddr,
   input  logic [ddm_pkg::DATAW-1:0]   pwdata,
   output logic [ddm_pkg::DATAW-1:0]   prdata,
   output logic                        pready,
   output ddm_pkg::cfg_type            cfg
);

   ddm_pkg::cfg_type      cfg_ff;
   ddm_pkg::cfg_type      cfg_in;
   ddm_pkg::reg_addr_type addr;
   ddm_pkg::mag_type      wr_limit;
   logic                  wr_en;

   assign addr     = ddm_pkg::reg_addr_type'(paddr[ddm_pkg::ADDRW-1:2]);
   assign wr_en    = psel && penable && pwrite;
   assign wr_limit = (pwdata[ddm_pkg::QFRAC:0] > ddm_pkg::QONE) ?
                     ddm_pkg::QONE : pwdata[ddm_pkg::QFRAC:0];
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (addr)
            ddm_pkg::REG_MAX_SPEED:  cfg_in.max_speed       = wr_limit;
            ddm_pkg::REG_BACKWARD:   cfg_in.backward_factor = wr_limit;
            ddm_pkg::REG_ADV_INVERT: cfg_in.advance_invert  = pwdata[0];
            ddm_pkg::REG_TRN_INVERT: cfg_in.turn_invert     = pwdata[0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (addr)
         ddm_pkg::REG_MAX_SPEED:
            prdata = ddm_pkg::DATAW'(cfg_ff.max_speed);
         ddm_pkg::REG_BACKWARD:
            prdata = ddm_pkg::DATAW'(cfg_ff.backward_factor);
         ddm_pkg::REG_ADV_INVERT:
            prdata = ddm_pkg::DATAW'(cfg_ff.advance_invert);
         ddm_pkg::REG_TRN_INVERT:
            prdata = ddm_pkg::DATAW'(cfg_ff.turn_invert);
         default:
            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_speed       <= ddm_pkg::MAX_SPEED_RST;
         cfg_ff.backward_factor <= ddm_pkg::BACKWARD_RST;
         cfg_ff.advance_invert  <= 1'b0;
         cfg_ff.turn_invert     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/ddm_mix.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ddm_mix
// Four-stage front end: clamp and limit select, scaling multiplies, wheel
// sums, then magnitude compare that sets up the normalizing divide.
// ---------------------------------------------------------------------------
module ddm_mix (
   input  logic                    clock,
   input  logic                    reset,
   input  ddm_pkg::cfg_type        cfg,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  ddm_pkg::cmd_type        advance_cmd,
   input  ddm_pkg::cmd_type        turn_cmd,
   output logic                    out_valid,
   input  logic                    out_ready,
   output ddm_pkg::div_in_type     out_data
);

   localparam int PW = 2 * (ddm_pkg::QFRAC + 1);

   function automatic ddm_pkg::mag_type clamp_mag(input ddm_pkg::cmd_type v);
      logic [ddm_pkg::CMDW:0] a;
      a = v[ddm_pkg::CMDW-1] ? ((ddm_pkg::CMDW+1)'(0) - {1'b1, v}) : {1'b0, v};
      return (a > (ddm_pkg::CMDW+1)'(ddm_pkg::QONE)) ? ddm_pkg::QONE :
             a[ddm_pkg::QFRAC:0];
   endfunction

   function automatic ddm_pkg::wsum_type to_signed(input logic neg,
                                                   input ddm_pkg::mag_type m);
      ddm_pkg::wsum_type s;
      s = ddm_pkg::wsum_type'({2'b00, m});
      return neg ? -s : s;
   endfunction

   function automatic ddm_pkg::wmag_type abs_mag(input ddm_pkg::wsum_type v);
      ddm_pkg::wsum_type t;
      t = v[ddm_pkg::QFRAC+2] ? -v : v;
      return t[ddm_pkg::QFRAC+1:0];
   endfunction

   // stage A
   logic                 a_valid_ff;
   logic                 a_adv_neg_ff, a_trn_neg_ff;
   ddm_pkg::mag_type     a_adv_mag_ff, a_trn_mag_ff, a_limit_ff;
   logic                 a_adv_neg_in, a_trn_neg_in;
   ddm_pkg::mag_type     a_adv_mag_in, a_trn_mag_in, a_limit_in;
   // stage B
   logic                 b_valid_ff;
   logic                 b_adv_neg_ff, b_trn_neg_ff;
   ddm_pkg::mag_type     b_base_ff, b_eff_ff;
   logic [PW-1:0]        b_base_prod, b_eff_prod;
   // stage C
   logic                 c_valid_ff;
   ddm_pkg::wsum_type    c_left_ff, c_right_ff;
   ddm_pkg::wsum_type    c_base, c_eff;
   // stage D
   logic                 d_valid_ff;
   ddm_pkg::div_in_type  d_data_ff, d_data_in;
   ddm_pkg::wmag_type    d_lm, d_rm;

   logic en_a, en_b, en_c, en_d;

   assign en_d     = !d_valid_ff || out_ready;
   assign en_c     = !c_valid_ff || en_d;
   assign en_b     = !b_valid_ff || en_c;
   assign en_a     = !a_valid_ff || en_b;
   assign in_ready = en_a;

   always_comb begin
      a_adv_mag_in = clamp_mag(advance_cmd);
      a_trn_mag_in = clamp_mag(turn_cmd);
      a_adv_neg_in = (advance_cmd[ddm_pkg::CMDW-1] ^ cfg.advance_invert) &&
                     (a_adv_mag_in != '0);
      a_trn_neg_in = (turn_cmd[ddm_pkg::CMDW-1] ^ cfg.turn_invert) &&
                     (a_trn_mag_in != '0);
      a_limit_in   = a_adv_neg_in ? cfg.backward_factor : cfg.max_speed;
   end

   assign b_base_prod = PW'(a_adv_mag_ff) * PW'(a_limit_ff);
   assign b_eff_prod  = PW'(a_trn_mag_ff) * PW'(a_limit_ff);

   assign c_base = to_signed(b_adv_neg_ff, b_base_ff);
   assign c_eff  = to_signed(b_trn_neg_ff, b_eff_ff);

   always_comb begin
      d_lm = abs_mag(c_left_ff);
      d_rm = abs_mag(c_right_ff);
      d_data_in.side.norm      = (d_lm > ddm_pkg::wmag_type'(ddm_pkg::QONE)) ||
                                 (d_rm > ddm_pkg::wmag_type'(ddm_pkg::QONE));
      d_data_in.side.left_big  = (d_lm >= d_rm);
      d_data_in.side.equal     = (d_lm == d_rm);
      d_data_in.side.left_neg  = c_left_ff[ddm_pkg::QFRAC+2];
      d_data_in.side.right_neg = c_right_ff[ddm_pkg::QFRAC+2];
      d_data_in.side.left_mag  = d_lm;
      d_data_in.side.right_mag = d_rm;
      d_data_in.num            = (d_lm >= d_rm) ? d_rm : d_lm;
      d_data_in.den            = (d_lm >= d_rm) ? d_lm : d_rm;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (en_a) a_valid_ff <= in_valid;
         if (en_b) b_valid_ff <= a_valid_ff;
         if (en_c) c_valid_ff <= b_valid_ff;
         if (en_d) d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_adv_neg_ff <= a_adv_neg_in;
         a_trn_neg_ff <= a_trn_neg_in;
         a_adv_mag_ff <= a_adv_mag_in;
         a_trn_mag_ff <= a_trn_mag_in;
         a_limit_ff   <= a_limit_in;
      end
      if (en_b) begin
         b_adv_neg_ff <= a_adv_neg_ff;
         b_trn_neg_ff <= a_trn_neg_ff;
         b_base_ff    <= b_base_prod[2*ddm_pkg::QFRAC:ddm_pkg::QFRAC];
         b_eff_ff     <= b_eff_prod[2*ddm_pkg::QFRAC:ddm_pkg::QFRAC];
      end
      if (en_c) begin
         c_left_ff  <= c_base - c_eff;
         c_right_ff <= c_base + c_eff;
      end
      if (en_d) begin
         d_data_ff <= d_data_in;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_data  = d_data_ff;

endmodule

>>> rtl/ddm_norm.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ddm_norm
// Pipelined restoring divide of the smaller wheel magnitude by the larger,
// one quotient bit per stage, then the signed result register.
// ---------------------------------------------------------------------------
module ddm_norm (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  ddm_pkg::div_in_type     in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output ddm_pkg::cmd_type        left_speed,
   output ddm_pkg::cmd_type        right_speed
);

   localparam int NS = ddm_pkg::NSTEP;
   localparam int WW = ddm_pkg::QFRAC + 2;

   logic [NS-1:0]        valid_ff;
   logic [NS:0]          en;
   ddm_pkg::wmag_type    rem_ff  [NS];
   ddm_pkg::wmag_type    den_ff  [NS];
   ddm_pkg::quo_type     quo_ff  [NS];
   ddm_pkg::side_type    side_ff [NS];

   logic                 out_valid_ff;
   ddm_pkg::cmd_type     left_ff, right_ff;
   ddm_pkg::cmd_type     left_in, right_in;
   ddm_pkg::side_type    fs;
   ddm_pkg::mag_type     small_mag, left_mag, right_mag;

   assign en[NS]   = !out_valid_ff || out_ready;
   assign in_ready = en[0];

   for (genvar k = 0; k < NS; k++) begin : g_step
      ddm_pkg::wmag_type  rem_src, den_src;
      ddm_pkg::quo_type   quo_src;
      ddm_pkg::side_type  side_src;
      logic               valid_src;
      logic [WW:0]        r2;
      logic               ge;

      if (k == 0) begin : g_head
         assign rem_src   = in_data.num;
         assign den_src   = in_data.den;
         assign quo_src   = '0;
         assign side_src  = in_data.side;
         assign valid_src = in_valid;
      end else begin : g_body
         assign rem_src   = rem_ff[k-1];
         assign den_src   = den_ff[k-1];
         assign quo_src   = quo_ff[k-1];
         assign side_src  = side_ff[k-1];
         assign valid_src = valid_ff[k-1];
      end

      assign en[k] = !valid_ff[k] || en[k+1];
      assign r2    = {rem_src, 1'b0};
      assign ge    = (r2 >= {1'b0, den_src});

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en[k]) begin
            valid_ff[k] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rem_ff[k]  <= ge ? WW'(r2 - {1'b0, den_src}) : r2[WW-1:0];
            den_ff[k]  <= den_src;
            quo_ff[k]  <= {quo_src[ddm_pkg::QFRAC-2:0], ge};
            side_ff[k] <= side_src;
         end
      end
   end

   always_comb begin
      fs        = side_ff[NS-1];
      small_mag = fs.equal ? ddm_pkg::QONE : {1'b0, quo_ff[NS-1]};
      if (fs.norm) begin
         left_mag  = fs.left_big ? ddm_pkg::QONE : small_mag;
         right_mag = (fs.left_big && !fs.equal) ? small_mag : ddm_pkg::QONE;
      end else begin
         left_mag  = fs.left_mag[ddm_pkg::QFRAC:0];
         right_mag = fs.right_mag[ddm_pkg::QFRAC:0];
      end
      left_in  = fs.left_neg  ? -ddm_pkg::cmd_type'({1'b0, left_mag}) :
                                 ddm_pkg::cmd_type'({1'b0, left_mag});
      right_in = fs.right_neg ? -ddm_pkg::cmd_type'({1'b0, right_mag}) :
                                 ddm_pkg::cmd_type'({1'b0, right_mag});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en[NS]) begin
         out_valid_ff <= valid_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en[NS]) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   assign out_valid   = out_valid_ff;
   assign left_speed  = left_ff;
   assign right_speed = right_ff;

endmodule

>>> rtl/differential_drive_mixer.sv
`timescale 1ns / 1ps
// Path: mix stages A to D, quotient steps, then the result register.
// Throughput: one item per cycle unless stalled; 14-stage quotient pipe.
// Each stage holds on its own when the next is full, so bubbles collapse.
// Reset clears all valid bits and loads the register defaults.
// ---------------------------------------------------------------------------
// differential_drive_mixer
// Arcade-style mixer of advance and turn commands into normalized wheel
// speeds, with an APB-style register port.
// ---------------------------------------------------------------------------
module differential_drive_mixer (
   input  logic                        clock,
   input  logic                        reset,
   ddm_req_if.sink                     req_ch,
   ddm_rsp_if.source                   rsp_ch,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [ddm_pkg::ADDRW-1:0]   csr_paddr,
   input  logic [ddm_pkg::DATAW-1:0]   csr_pwdata,
   output logic [ddm_pkg::DATAW-1:0]   csr_prdata,
   output logic                        csr_pready
);

   ddm_pkg::cfg_type     cfg;
   logic                 mix_valid, mix_ready;
   ddm_pkg::div_in_type  mix_data;

   ddm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   ddm_mix u_mix (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (req_ch.valid),
      .in_ready    (req_ch.ready),
      .advance_cmd (req_ch.advance_cmd),
      .turn_cmd    (req_ch.turn_cmd),
      .out_valid   (mix_valid),
      .out_ready   (mix_ready),
      .out_data    (mix_data)
   );

   ddm_norm u_norm (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (mix_valid),
      .in_ready    (mix_ready),
      .in_data     (mix_data),
      .out_valid   (rsp_ch.valid),
      .out_ready   (rsp_ch.ready),
      .left_speed  (rsp_ch.left_speed),
      .right_speed (rsp_ch.right_speed)
   );

endmodule

>>> rtl/ddm_chk.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ddm_chk
// Port-level checks of the mixer: reset, result hold and output range.
// ---------------------------------------------------------------------------
module ddm_chk (
   input  logic               clock,
   input  logic               reset,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [15:0] rsp_left_speed,
   input  logic signed [15:0] rsp_right_speed
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left_speed) &&
                                  $stable(rsp_right_speed))
      else $error("stalled item changed");

   a_left_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_left_speed >= -16'sd16384) && (rsp_left_speed <= 16'sd16384))
      else $error("left speed beyond 1.0");

   a_right_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_right_speed >= -16'sd16384) && (rsp_right_speed <= 16'sd16384))
      else $error("right speed beyond 1.0");

endmodule

bind differential_drive_mixer ddm_chk u_ddm_chk (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_left_speed  (rsp_ch.left_speed),
   .rsp_right_speed (rsp_ch.right_speed)
);
